[sv/etxfb_pkg.sv]
`default_nettype none

package etxfb_pkg;

   // Field widths fixed by the frame format.
   localparam int LEN_W       = 16;
   localparam int ADDR_W      = 48;
   localparam int OCTET_W     = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 48;

   // Command codes on the request channel.
   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_PAYLOAD = 1'b1;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_LENGTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_ADDRESS   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_ADDRESS = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_MODE   = 2'd3;

   // Fixed header octets.
   localparam logic [OCTET_W-1:0] PREAMBLE_BYTE = 8'hAA;
   localparam logic [OCTET_W-1:0] DELIM_BYTE    = 8'hAB;

   // Work queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // One unit of work for the back part: a whole header or one payload octet.
   typedef struct packed {
      logic               is_header;
      logic [OCTET_W-1:0] octet;
      logic               last;
   } entry_type;

   // Configuration register contents.
   typedef struct packed {
      logic [LEN_W-1:0]  frame_length;
      logic [ADDR_W-1:0] dest_address;
      logic [ADDR_W-1:0] source_address;
      logic              pattern_mode;
   } cfg_type;

   // Queue status seen by both sides.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   // Back part sequencer states.
   typedef enum logic {
      ST_IDLE,
      ST_HEADER
   } state_type;

endpackage

`default_nettype wire

[sv/etxfb_front.sv]
`default_nettype none

module etxfb_front
   import etxfb_pkg::*;
#(
   parameter int MAX_PAYLOAD = 1500
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_cmd,
   input  wire logic [OCTET_W-1:0] req_client_octet,
   input  wire cfg_type            cfg,
   input  wire queue_stat_type     qstat,
   output logic                    push,
   output entry_type               push_entry
);

   localparam logic [LEN_W-1:0] MAX_COUNT = LEN_W'(MAX_PAYLOAD);

   logic             active_ff, active_in;
   logic [LEN_W-1:0] index_ff, index_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic             pattern_ff, pattern_in;
   logic             accept;
   logic [LEN_W-1:0] start_count;
   logic [LEN_W:0]   next_index;
   logic             payload_last;

   assign req_ready = !qstat.full;
   assign accept    = req_valid && req_ready;

   // Payload count saturates, the length field itself is sent unchanged.
   assign start_count  = (cfg.frame_length > MAX_COUNT) ? MAX_COUNT : cfg.frame_length;
   assign next_index   = {1'b0, index_ff} + (LEN_W+1)'(1);
   assign payload_last = next_index >= {1'b0, count_ff};

   // Classify each transfer and track the open frame.
   always_comb begin
      active_in  = active_ff;
      index_in   = index_ff;
      count_in   = count_ff;
      pattern_in = pattern_ff;
      push       = 1'b0;
      push_entry = '0;
      if (accept) begin
         if (req_cmd == CMD_START) begin
            push                 = 1'b1;
            push_entry.is_header = 1'b1;
            push_entry.octet     = PREAMBLE_BYTE;
            push_entry.last      = (start_count == '0);
            count_in             = start_count;
            pattern_in           = cfg.pattern_mode;
            index_in             = '0;
            active_in            = (start_count != '0);
         end else if (active_ff) begin
            push                 = 1'b1;
            push_entry.is_header = 1'b0;
            push_entry.octet     = pattern_ff ? index_ff[OCTET_W-1:0] : req_client_octet;
            push_entry.last      = payload_last;
            index_in             = next_index[LEN_W-1:0];
            if (payload_last) begin
               active_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         index_ff   <= '0;
         count_ff   <= '0;
         pattern_ff <= 1'b0;
      end else begin
         active_ff  <= active_in;
         index_ff   <= index_in;
         count_ff   <= count_in;
         pattern_ff <= pattern_in;
      end
   end

endmodule

`default_nettype wire

[sv/etxfb_queue.sv]
`default_nettype none

module etxfb_queue
   import etxfb_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   input  wire logic      pop,
   output entry_type      head,
   output queue_stat_type qstat
);

   localparam logic [QPTR_W-1:0] LAST_SLOT = QPTR_W'(QUEUE_DEPTH - 1);

   entry_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign head        = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

[sv/etxfb_back.sv]
`default_nettype none

module etxfb_back
   import etxfb_pkg::*;
#(
   parameter int PREAMBLE_OCTETS = 7
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire cfg_type        cfg,
   input  wire entry_type      head,
   input  wire queue_stat_type qstat,
   output logic                pop,
   output state_type           state,
   input  wire logic           rsp_ready,
   output logic                rsp_valid,
   output logic [OCTET_W-1:0]  rsp_octet,
   output logic                rsp_last
);

   // Header: preamble, delimiter, two addresses, two length octets.
   localparam int HDR_LEN = PREAMBLE_OCTETS + 15;
   localparam int HIDX_W  = $clog2(HDR_LEN);
   localparam logic [HIDX_W-1:0] IDX_DELIM  = HIDX_W'(PREAMBLE_OCTETS);
   localparam logic [HIDX_W-1:0] IDX_DEST   = HIDX_W'(PREAMBLE_OCTETS + 1);
   localparam logic [HIDX_W-1:0] IDX_SOURCE = HIDX_W'(PREAMBLE_OCTETS + 7);
   localparam logic [HIDX_W-1:0] IDX_LEN_LO = HIDX_W'(PREAMBLE_OCTETS + 13);
   localparam logic [HIDX_W-1:0] IDX_LAST   = HIDX_W'(PREAMBLE_OCTETS + 14);

   state_type           state_ff, state_in;
   logic [HIDX_W-1:0]   idx_ff, idx_in;
   logic                hdr_last_ff, hdr_last_in;
   logic                valid_ff, valid_in;
   logic [OCTET_W-1:0]  octet_ff, octet_in;
   logic                last_ff, last_in;
   logic                out_free;
   logic                load;
   logic [HIDX_W-1:0]   dest_off;
   logic [HIDX_W-1:0]   source_off;
   logic [ADDR_W-1:0]   dest_shift;
   logic [ADDR_W-1:0]   source_shift;
   logic [OCTET_W-1:0]  hdr_octet;

   assign state     = state_ff;
   assign rsp_valid = valid_ff;
   assign rsp_octet = octet_ff;
   assign rsp_last  = last_ff;

   // The output register can take a new octet when empty or being drained.
   assign out_free = !valid_ff || rsp_ready;

   // Header octet selected by the position counter.
   assign dest_off     = idx_ff - IDX_DEST;
   assign source_off   = idx_ff - IDX_SOURCE;
   assign dest_shift   = cfg.dest_address >> {dest_off[2:0], 3'b000};
   assign source_shift = cfg.source_address >> {source_off[2:0], 3'b000};

   always_comb begin
      hdr_octet = PREAMBLE_BYTE;
      if (idx_ff == IDX_DELIM) begin
         hdr_octet = DELIM_BYTE;
      end else if (idx_ff >= IDX_DEST && idx_ff < IDX_SOURCE) begin
         hdr_octet = dest_shift[OCTET_W-1:0];
      end else if (idx_ff >= IDX_SOURCE && idx_ff < IDX_LEN_LO) begin
         hdr_octet = source_shift[OCTET_W-1:0];
      end else if (idx_ff == IDX_LEN_LO) begin
         hdr_octet = cfg.frame_length[OCTET_W-1:0];
      end else if (idx_ff == IDX_LAST) begin
         hdr_octet = cfg.frame_length[LEN_W-1:OCTET_W];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (out_free && !qstat.empty && head.is_header) begin
               state_in = ST_HEADER;
            end
         end
         ST_HEADER: begin
            if (out_free && idx_ff == IDX_LAST) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      pop         = 1'b0;
      load        = 1'b0;
      idx_in      = idx_ff;
      hdr_last_in = hdr_last_ff;
      octet_in    = octet_ff;
      last_in     = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (out_free && !qstat.empty) begin
               pop  = 1'b1;
               load = 1'b1;
               if (head.is_header) begin
                  // The first preamble octet leaves with the pop.
                  octet_in    = PREAMBLE_BYTE;
                  last_in     = 1'b0;
                  idx_in      = HIDX_W'(1);
                  hdr_last_in = head.last;
               end else begin
                  octet_in = head.octet;
                  last_in  = head.last;
               end
            end
         end
         ST_HEADER: begin
            if (out_free) begin
               load     = 1'b1;
               octet_in = hdr_octet;
               last_in  = (idx_ff == IDX_LAST) ? hdr_last_ff : 1'b0;
               idx_in   = idx_ff + HIDX_W'(1);
            end
         end
         default: begin
         end
      endcase
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         idx_ff      <= '0;
         hdr_last_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         hdr_last_ff <= hdr_last_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      octet_ff <= octet_in;
      last_ff  <= last_in;
   end

endmodule

`default_nettype wire

[sv/ethernet_tx_frame_builder.sv]
`default_nettype none

// Ethernet transmit framer producing a GMII octet stream without FCS or padding.
// A start command (req_cmd = 0) sends PREAMBLE_OCTETS preamble octets, the start
// delimiter, destination and source addresses and the length/type field, all
// least significant octet first, as PREAMBLE_OCTETS + 15 result transfers that
// rsp_ready can hold; the back sequencer that walks the header sets this figure.
// Each payload command (req_cmd = 1) inside an open frame yields one octet, and
// payload octets flow at one per cycle while rsp_ready is high; payload commands
// outside a frame are accepted and dropped. The payload count is frame_length
// saturated at MAX_PAYLOAD and is taken, with pattern_mode, when the frame
// starts. A two-entry queue sits between the request side and the header
// sequencer, so requests keep being accepted while a header is still being sent
// until the queue is full. Write registers only while no transfer is outstanding.
module ethernet_tx_frame_builder
   import etxfb_pkg::*;
#(
   parameter int PREAMBLE_OCTETS = 7,
   parameter int MAX_PAYLOAD     = 1500
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_cmd,
   input  wire logic [OCTET_W-1:0]     req_client_octet,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [OCTET_W-1:0]          rsp_gmii_octet,
   output logic                        rsp_gmii_error,
   output logic                        rsp_frame_end,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   cfg_type        cfg_ff;
   queue_stat_type qstat;
   entry_type      push_entry;
   entry_type      head;
   logic           push;
   logic           pop;
   state_type      state;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_LENGTH:   cfg_ff.frame_length   <= csr_write_data[LEN_W-1:0];
            CSR_DEST_ADDRESS:   cfg_ff.dest_address   <= csr_write_data[ADDR_W-1:0];
            CSR_SOURCE_ADDRESS: cfg_ff.source_address <= csr_write_data[ADDR_W-1:0];
            CSR_PATTERN_MODE:   cfg_ff.pattern_mode   <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   etxfb_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_client_octet (req_client_octet),
      .cfg              (cfg_ff),
      .qstat            (qstat),
      .push             (push),
      .push_entry       (push_entry)
   );

   etxfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   etxfb_back #(
      .PREAMBLE_OCTETS (PREAMBLE_OCTETS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .qstat     (qstat),
      .pop       (pop),
      .state     (state),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_octet (rsp_gmii_octet),
      .rsp_last  (rsp_frame_end)
   );

   assign rsp_gmii_error = 1'b0;

   // The queue is never written while full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full)
      else $error("work queue written while full");

   // The queue is only read when it holds an entry.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("work queue read while empty");

   // No queue entry is taken while a header is being sent.
   a_header_holds_queue: assert property (@(posedge clock) disable iff (reset)
      (state == ST_HEADER) |-> !pop)
      else $error("queue popped during header");

   // Nothing is offered right after reset.
   a_reset_idle: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result offered right after reset");

endmodule

`default_nettype wire
